// ===== hdl/width_selectable_integer_alu_defines.svh =====
// ----------------------------------------------------------------------------
// width_selectable_integer_alu_defines
// Assertion macros for the integer ALU; empty bodies for synthesis.
// ----------------------------------------------------------------------------
`ifndef WIDTH_SELECTABLE_INTEGER_ALU_DEFINES_SVH
`define WIDTH_SELECTABLE_INTEGER_ALU_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define WSALU_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wsalu: same-cycle check failed");
// next-cycle implication
`define WSALU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wsalu: next-cycle check failed");
`else
`define WSALU_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define WSALU_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/wsalu_pkg.sv =====
// ----------------------------------------------------------------------------
// wsalu_pkg
// Types, codes and helper functions of the width-selectable integer ALU.
// ----------------------------------------------------------------------------
package wsalu_pkg;

  localparam int FULL_WIDTH = 32;
  localparam int CNT_W      = 6;   // holds FULL_WIDTH itself

  localparam logic [31:0] HI16_MASK = 32'hFFFF0000;
  localparam logic [31:0] HI24_MASK = 32'hFFFFFF00;
  localparam logic [31:0] LO16_MASK = 32'h0000FFFF;
  localparam logic [31:0] LO8_MASK  = 32'h000000FF;

  typedef enum logic [1:0] {
    WS_32 = 2'd0,
    WS_16 = 2'd1,
    WS_8  = 2'd2,
    WS_RSV = 2'd3
  } width_sel_t;

  typedef enum logic [0:0] {
    REG_WIDTH_SELECT = 1'b0,
    REG_SIGNED_MODE  = 1'b1
  } reg_idx_t;

  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,
    OP_SUB  = 4'd1,
    OP_MUL  = 4'd2,
    OP_DIV  = 4'd3,
    OP_MOD  = 4'd4,
    OP_AND  = 4'd5,
    OP_OR   = 4'd6,
    OP_XOR  = 4'd7,
    OP_SHL  = 4'd8,
    OP_SHR  = 4'd9,
    OP_ROL  = 4'd10,
    OP_ROR  = 4'd11,
    OP_NOT  = 4'd12,
    OP_ABS  = 4'd13,
    OP_SQRT = 4'd14,
    OP_CONV = 4'd15
  } op_t;

  typedef struct packed {
    logic [3:0]  action;
    logic [31:0] accumulator_value;
    logic [31:0] entry_value;
  } in_t;

  typedef struct packed {
    logic [31:0] result;
    logic        divide_error;
  } out_t;

  // truncate to the word width, sign-extend in signed mode
  function automatic logic [31:0] fit_width(input logic [31:0] v, input logic [1:0] ws,
                                            input logic sgn);
    logic [31:0] r;
    r = v;
    case (width_sel_t'(ws))
      WS_16: begin
        r = v & LO16_MASK;
        if (sgn && v[15]) r = r | HI16_MASK;
      end
      WS_8: begin
        r = v & LO8_MASK;
        if (sgn && v[7]) r = r | HI24_MASK;
      end
      default: r = v;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] width_mask(input logic [1:0] ws);
    logic [31:0] m;
    case (width_sel_t'(ws))
      WS_16:   m = LO16_MASK;
      WS_8:    m = LO8_MASK;
      default: m = '1;
    endcase
    return m;
  endfunction

  // rotate count modulo the word width
  function automatic logic [CNT_W-1:0] rot_count(input logic [31:0] b, input logic [1:0] ws);
    logic [CNT_W-1:0] n;
    case (width_sel_t'(ws))
      WS_16:   n = CNT_W'(b[3:0]);
      WS_8:    n = CNT_W'(b[2:0]);
      default: n = CNT_W'(b[4:0]);
    endcase
    return n;
  endfunction

  // one-bit rotate inside the word width; bits above the width stay zero
  function automatic logic [31:0] rot1(input logic [31:0] v, input logic [1:0] ws,
                                       input logic left);
    logic [31:0] r;
    case (width_sel_t'(ws))
      WS_16:   r = left ? {16'd0, v[14:0], v[15]} : {16'd0, v[0], v[15:1]};
      WS_8:    r = left ? {24'd0, v[6:0], v[7]}   : {24'd0, v[0], v[7:1]};
      default: r = left ? {v[30:0], v[31]}        : {v[0], v[31:1]};
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/width_selectable_integer_alu.sv =====
// ----------------------------------------------------------------------------
// width_selectable_integer_alu
// Integer ALU with selectable 8/16/32-bit word width and signed mode.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: present in_data with start high; the transaction is taken
//   at a clock edge where start is high and busy is low. busy stays high from
//   the cycle after acceptance until the result has been issued.
//   Result channel: out_valid is high for exactly one cycle with out_data;
//   the receiver cannot stall, so the result must be captured then.
//   Configuration: cfg_we writes cfg_wdata to the register at cfg_index
//   (0 word width, 1 signed mode); write only while busy is low.
// Operation: add, sub, logic, not, abs, convert, long shifts and divide by zero
//   are issued from S_RUN without stepping. Multiply, divide and modulo
//   step one bit per cycle through a shift-add/restoring-subtract loop.
//   Square root retires two radicand bits a cycle. Shifts and rotates move
//   one bit a cycle until the shift or rotate count runs out.
// Ordering: one transaction at a time; the next may start in the cycle
//   out_valid is high.
// Reset: rst_n (synchronous, active low) returns to idle, drops any
//   transaction in flight and clears both configuration registers.
// ----------------------------------------------------------------------------
`include "width_selectable_integer_alu_defines.svh"

module width_selectable_integer_alu
  import wsalu_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  in_t        in_data,
  output logic       out_valid,
  output out_t       out_data,
  input  logic       cfg_we,
  input  logic [0:0] cfg_index,
  input  logic [1:0] cfg_wdata
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } state_t;

  state_t           state_r, state_nxt;
  op_t              op_r, op_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [31:0]      x_r, x_nxt;      // shifting operand / quotient / rotate word
  logic [31:0]      y_r, y_nxt;      // multiplier or divisor
  logic [31:0]      z_r, z_nxt;      // product, root or direct result
  logic [31:0]      rem_r, rem_nxt;  // partial remainder
  logic             err_r, err_nxt;
  logic [1:0]       width_sel_r;
  logic             signed_mode_r;
  logic             out_valid_r, out_valid_nxt;
  out_t             out_data_r, out_data_nxt;

  logic        accept;
  logic [31:0] a_in, b_in;
  logic [32:0] div_trial;
  logic [33:0] sq_rem, sq_trial;
  logic [31:0] final_val;

  assign accept = start && (state_r == S_IDLE);
  assign a_in   = in_data.accumulator_value;
  assign b_in   = in_data.entry_value;

  assign div_trial = {rem_r, x_r[31]};
  assign sq_rem    = {rem_r, x_r[31:30]};
  assign sq_trial  = {z_r, 2'b01};

  always_comb begin
    case (op_r)
      OP_DIV, OP_SHL, OP_SHR, OP_ROL, OP_ROR: final_val = x_r;
      OP_MOD:                                 final_val = rem_r;
      default:                                final_val = z_r;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    cnt_nxt       = cnt_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    z_nxt         = z_r;
    rem_nxt       = rem_r;
    err_nxt       = err_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;

    if (accept) begin
      state_nxt = S_RUN;
      op_nxt    = op_t'(in_data.action);
      cnt_nxt   = '0;
      x_nxt     = a_in;
      y_nxt     = b_in;
      z_nxt     = '0;
      rem_nxt   = '0;
      err_nxt   = 1'b0;
      case (op_t'(in_data.action))
        OP_ADD: z_nxt = a_in + b_in;
        OP_SUB: z_nxt = a_in - b_in;
        OP_MUL: cnt_nxt = CNT_W'(FULL_WIDTH);
        OP_DIV, OP_MOD: begin
          if (b_in == '0) begin
            err_nxt = 1'b1;
            x_nxt   = '0;
          end else begin
            cnt_nxt = CNT_W'(FULL_WIDTH);
          end
        end
        OP_AND: z_nxt = a_in & b_in;
        OP_OR:  z_nxt = a_in | b_in;
        OP_XOR: z_nxt = a_in ^ b_in;
        OP_SHL, OP_SHR: begin
          if (b_in >= 32'(FULL_WIDTH)) x_nxt = '0;
          else                         cnt_nxt = CNT_W'(b_in[4:0]);
        end
        OP_ROL, OP_ROR: begin
          x_nxt   = a_in & width_mask(width_sel_r);
          cnt_nxt = rot_count(b_in, width_sel_r);
        end
        OP_NOT: z_nxt = ~b_in;
        OP_ABS: z_nxt = (signed_mode_r && b_in[31]) ? (32'd0 - b_in) : b_in;
        OP_SQRT: begin
          // signed mode passes negative values and zero unchanged
          if (signed_mode_r && (b_in[31] || (b_in == '0))) begin
            z_nxt = b_in;
          end else begin
            x_nxt   = b_in;
            cnt_nxt = CNT_W'(FULL_WIDTH / 2);
          end
        end
        default: z_nxt = b_in;
      endcase
    end else if (state_r == S_RUN) begin
      if (cnt_r == '0) begin
        // issue the transaction result and drop back to idle
        state_nxt                 = S_IDLE;
        out_valid_nxt             = 1'b1;
        out_data_nxt.result       = fit_width(final_val, width_sel_r, signed_mode_r);
        out_data_nxt.divide_error = err_r;
      end else begin
        cnt_nxt = cnt_r - CNT_W'(1);
        case (op_r)
          OP_MUL: begin
            if (y_r[0]) z_nxt = z_r + x_r;
            x_nxt = {x_r[30:0], 1'b0};
            y_nxt = {1'b0, y_r[31:1]};
          end
          OP_DIV, OP_MOD: begin
            if (div_trial >= {1'b0, y_r}) begin
              rem_nxt = 32'(div_trial - {1'b0, y_r});
              x_nxt   = {x_r[30:0], 1'b1};
            end else begin
              rem_nxt = div_trial[31:0];
              x_nxt   = {x_r[30:0], 1'b0};
            end
          end
          OP_SHL: x_nxt = {x_r[30:0], 1'b0};
          OP_SHR: x_nxt = {1'b0, x_r[31:1]};
          OP_ROL: x_nxt = rot1(x_r, width_sel_r, 1'b1);
          OP_ROR: x_nxt = rot1(x_r, width_sel_r, 1'b0);
          OP_SQRT: begin
            x_nxt = {x_r[29:0], 2'b00};
            if (sq_rem >= sq_trial) begin
              rem_nxt = 32'(sq_rem - sq_trial);
              z_nxt   = {z_r[30:0], 1'b1};
            end else begin
              rem_nxt = sq_rem[31:0];
              z_nxt   = {z_r[30:0], 1'b0};
            end
          end
          default: cnt_nxt = '0;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      out_valid_r   <= 1'b0;
      width_sel_r   <= '0;
      signed_mode_r <= 1'b0;
      cnt_r         <= '0;
      op_r          <= OP_ADD;
      err_r         <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      op_r        <= op_nxt;
      err_r       <= err_nxt;
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_WIDTH_SELECT: width_sel_r   <= cfg_wdata;
          REG_SIGNED_MODE:  signed_mode_r <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    z_r        <= z_nxt;
    rem_r      <= rem_nxt;
    out_data_r <= out_data_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `WSALU_ASSERT_NEXT(a_accept_busy, clk, rst_n, accept, busy)
  `WSALU_ASSERT_IMPL(a_result_when_idle, clk, rst_n, out_valid, !busy)
  `WSALU_ASSERT_IMPL(a_err_only_divide, clk, rst_n, out_valid && out_data.divide_error,
                     (op_r == OP_DIV) || (op_r == OP_MOD))
  `WSALU_ASSERT_IMPL(a_count_bound, clk, rst_n, state_r == S_RUN,
                     cnt_r <= CNT_W'(FULL_WIDTH))
  `WSALU_ASSERT_NEXT(a_one_result, clk, rst_n, out_valid, !out_valid)

endmodule

// ===== dv/alu_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alu_result_checker
// Watches the command, result and register ports of the integer ALU. It keeps
// its own copy of the word width and signed mode, works out the outcome of
// every accepted command and compares each issued result with the oldest one.
// ----------------------------------------------------------------------------
module alu_result_checker
  import wsalu_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  in_t         in_data,
  input  logic        out_valid,
  input  out_t        out_data,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [1:0]  cfg_wdata,
  output int unsigned mismatches,
  output int unsigned outstanding
);

  logic [1:0]  width_shadow;
  logic        signed_shadow;
  out_t        pending_results[$];
  int unsigned fail_cnt;

  function automatic logic [31:0] floor_root(input logic [31:0] s);
    logic [15:0]     root;
    logic [15:0]     trial;
    longint unsigned sq;
    root = '0;
    for (int i = 15; i >= 0; i--) begin
      trial = root | (16'd1 << i);
      sq    = longint'(trial) * longint'(trial);
      if (sq <= longint'(s)) root = trial;
    end
    return {16'd0, root};
  endfunction

  function automatic out_t alu_outcome(input in_t cmd, input logic [1:0] ws, input logic sg);
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] r;
    logic [31:0] msk;
    logic [31:0] v;
    logic        err;
    int unsigned w;
    int unsigned n;
    out_t        res;
    a   = cmd.accumulator_value;
    b   = cmd.entry_value;
    r   = '0;
    err = 1'b0;
    case (width_sel_t'(ws))
      WS_16:   w = 16;
      WS_8:    w = 8;
      default: w = 32;
    endcase
    msk = (w == 32) ? 32'hFFFFFFFF : ((32'd1 << w) - 32'd1);
    case (op_t'(cmd.action))
      OP_ADD: r = a + b;
      OP_SUB: r = a - b;
      OP_MUL: r = a * b;
      OP_DIV: begin
        if (b == 0) err = 1'b1;
        else r = a / b;
      end
      OP_MOD: begin
        if (b == 0) err = 1'b1;
        else r = a % b;
      end
      OP_AND: r = a & b;
      OP_OR:  r = a | b;
      OP_XOR: r = a ^ b;
      OP_SHL: r = (b >= 32) ? '0 : (a << b[4:0]);
      OP_SHR: r = (b >= 32) ? '0 : (a >> b[4:0]);
      OP_ROL, OP_ROR: begin
        // rotate inside the word, count modulo the width
        n = b & (w - 1);
        v = a & msk;
        if (n == 0) r = v;
        else if (op_t'(cmd.action) == OP_ROL) r = ((v << n) | (v >> (w - n))) & msk;
        else r = ((v >> n) | (v << (w - n))) & msk;
      end
      OP_NOT: r = ~b;
      OP_ABS: r = (sg && b[31]) ? (32'd0 - b) : b;
      OP_SQRT: r = (sg && (b[31] || b == 0)) ? b : floor_root(b);
      default: r = b;
    endcase
    case (width_sel_t'(ws))
      WS_16:   r = {{16{sg & r[15]}}, r[15:0]};
      WS_8:    r = {{24{sg & r[7]}}, r[7:0]};
      default: r = r;
    endcase
    res.result       = r;
    res.divide_error = err;
    return res;
  endfunction

  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      width_shadow  <= WS_32;
      signed_shadow <= 1'b0;
      pending_results.delete();
    end else begin
      // retire the oldest expectation before queueing a new transaction
      if (out_valid) begin
        if (pending_results.size() == 0) begin
          fail_cnt++;
          $display("%0t: unexpected result, expected none, actual result %h error %b",
                   $time, out_data.result, out_data.divide_error);
        end else begin
          want = pending_results.pop_front();
          if (out_data.result !== want.result) begin
            fail_cnt++;
            $display("%0t: result mismatch, expected %h, actual %h",
                     $time, want.result, out_data.result);
          end
          if (out_data.divide_error !== want.divide_error) begin
            fail_cnt++;
            $display("%0t: divide_error mismatch, expected %b, actual %b",
                     $time, want.divide_error, out_data.divide_error);
          end
        end
      end
      if (start && !busy)
        pending_results.push_back(alu_outcome(in_data, width_shadow, signed_shadow));
      if (cfg_we) begin
        if (cfg_index == REG_WIDTH_SELECT) width_shadow <= cfg_wdata;
        else signed_shadow <= cfg_wdata[0];
      end
    end
    mismatches  <= fail_cnt;
    outstanding <= pending_results.size();
  end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the integer ALU through a short directed set of corner commands and
// then random commands under every width and sign setting, with random idle
// bursts; the result checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
  import wsalu_pkg::*;

  localparam int PHASES        = 10;
  localparam int ITEMS_PER_PHASE = 90;
  localparam int DRAIN_CYCLES  = 40;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_t         in_data;
  logic        out_valid;
  out_t        out_data;
  logic        cfg_we;
  logic [0:0]  cfg_index;
  logic [1:0]  cfg_wdata;
  int unsigned mismatches;
  int unsigned outstanding;

  width_selectable_integer_alu u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  alu_result_checker u_result_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_data    (out_data),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic in_t make_cmd(input op_t op, input logic [31:0] a, input logic [31:0] b);
    in_t c;
    c.action            = op;
    c.accumulator_value = a;
    c.entry_value       = b;
    return c;
  endfunction

  // bias towards boundaries and short counts
  function automatic logic [31:0] pick_operand();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 12))
          0:  v = 32'h0;
          1:  v = 32'h1;
          2:  v = 32'h7FFFFFFF;
          3:  v = 32'h80000000;
          4:  v = 32'hFFFFFFFF;
          5:  v = 32'h000000FF;
          6:  v = 32'h00000080;
          7:  v = 32'h0000007F;
          8:  v = 32'h0000FFFF;
          9:  v = 32'h00008000;
          10: v = 32'h00007FFF;
          11: v = 32'h00000100;
          default: v = 32'h00010000;
        endcase
      end
      1, 2: v = $urandom_range(0, 40);
      3:    v = {{24{1'b1}}, 8'($urandom)};
      4:    v = 32'($urandom_range(0, 65535));
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // present one transaction and hold it until the block takes it
  task automatic issue(input in_t cmd);
    start   <= 1'b1;
    in_data <= cmd;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // drop start and wait until every expected result has come back
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // one write, then cfg_we low again before the task returns, so back-to-back writes never collide
  task automatic write_reg(input reg_idx_t idx, input logic [1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic [1:0] ws, input logic sg);
    logic [1:0] sdata;
    sdata = {1'($urandom_range(0, 1)), sg};
    if ($urandom_range(0, 1)) begin
      write_reg(REG_WIDTH_SELECT, ws);
      write_reg(REG_SIGNED_MODE, sdata);
    end else begin
      write_reg(REG_SIGNED_MODE, sdata);
      write_reg(REG_WIDTH_SELECT, ws);
    end
  endtask

  initial begin
    in_t         corner_cmds[$];
    in_t         cmd;
    logic [1:0]  ws;
    logic        sg;
    int unsigned idle_pct;
    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    corner_cmds.push_back(make_cmd(OP_ADD,  32'hFFFFFFFF, 32'h00000001));
    corner_cmds.push_back(make_cmd(OP_SUB,  32'h00000000, 32'h00000001));
    corner_cmds.push_back(make_cmd(OP_MUL,  32'hFFFFFFFF, 32'hFFFFFFFF));
    corner_cmds.push_back(make_cmd(OP_MUL,  32'h12345678, 32'h9ABCDEF0));
    corner_cmds.push_back(make_cmd(OP_DIV,  32'hFFFFFFFF, 32'h00000000));
    corner_cmds.push_back(make_cmd(OP_MOD,  32'h00000007, 32'h00000000));
    corner_cmds.push_back(make_cmd(OP_DIV,  32'hFFFFFFFF, 32'h00000003));
    corner_cmds.push_back(make_cmd(OP_MOD,  32'hFFFFFFFF, 32'h0000000A));
    corner_cmds.push_back(make_cmd(OP_AND,  32'hF0F0F0F0, 32'hFF00FF00));
    corner_cmds.push_back(make_cmd(OP_OR,   32'h0F0F0F0F, 32'h80000001));
    corner_cmds.push_back(make_cmd(OP_XOR,  32'hAAAAAAAA, 32'hFFFFFFFF));
    corner_cmds.push_back(make_cmd(OP_SHL,  32'hFFFFFFFF, 32'h00000020));
    corner_cmds.push_back(make_cmd(OP_SHL,  32'h00000001, 32'h0000001F));
    corner_cmds.push_back(make_cmd(OP_SHR,  32'h80000000, 32'hFFFFFFFF));
    corner_cmds.push_back(make_cmd(OP_SHR,  32'h80000000, 32'h0000001F));
    corner_cmds.push_back(make_cmd(OP_ROL,  32'h80000001, 32'h00000000));
    corner_cmds.push_back(make_cmd(OP_ROL,  32'h80000001, 32'h00000021));
    corner_cmds.push_back(make_cmd(OP_ROR,  32'h00000001, 32'h0000001F));
    corner_cmds.push_back(make_cmd(OP_NOT,  32'h12345678, 32'h00000000));
    corner_cmds.push_back(make_cmd(OP_ABS,  32'h00000000, 32'h80000000));
    corner_cmds.push_back(make_cmd(OP_ABS,  32'h00000000, 32'h7FFFFFFF));
    corner_cmds.push_back(make_cmd(OP_SQRT, 32'h00000000, 32'hFFFFFFFF));
    corner_cmds.push_back(make_cmd(OP_SQRT, 32'h00000000, 32'h00000000));
    corner_cmds.push_back(make_cmd(OP_SQRT, 32'h00000000, 32'h7FFFFFFF));
    corner_cmds.push_back(make_cmd(OP_CONV, 32'hFFFFFFFF, 32'h00000080));

    // corners run in 32-bit signed mode so abs and sqrt take their signed rules
    configure(WS_32, 1'b1);
    foreach (corner_cmds[i]) issue(corner_cmds[i]);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      // visit every width, reserved one included, in both sign modes first
      if (p < 8) begin
        ws = p[1:0];
        sg = p[2];
      end else begin
        ws = 2'($urandom_range(0, 3));
        sg = 1'($urandom_range(0, 1));
      end
      configure(ws, sg);
      case ($urandom_range(0, 2))
        0:       idle_pct = 0;
        1:       idle_pct = 25;
        default: idle_pct = 50;
      endcase
      // no idling in the closing phase
      if (p == PHASES - 1) idle_pct = 0;
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        cmd = make_cmd(op_t'($urandom_range(0, 15)), pick_operand(), pick_operand());
        if ((cmd.action == OP_DIV || cmd.action == OP_MOD) && $urandom_range(0, 7) == 0)
          cmd.entry_value = '0;
        issue(cmd);
        if ($urandom_range(1, 100) <= idle_pct) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 9)) @(posedge clk);
        end
      end
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/wsalu_pkg.sv
hdl/width_selectable_integer_alu.sv
dv/alu_result_checker.sv
dv/tb_top.sv
